/* src/parallel_port_nibble_link_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the parallel port nibble link
// Shared property templates used by the link's port checker.
// ---------------------------------------------------------------------------
`ifndef PARALLEL_PORT_NIBBLE_LINK_UNIT_MACROS_SVH
`define PARALLEL_PORT_NIBBLE_LINK_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PPNL_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (conseq)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPNL_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

/* src/ppnl_pkg.sv */
// ---------------------------------------------------------------------------
// Parallel port nibble link package
// Handshake phases, command codes and line values of the nibble link.
// ---------------------------------------------------------------------------
package ppnl_pkg;

    // Handshake phase, one-hot.
    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_TX_HI  = 6'b000010,
        PH_TX_LO  = 6'b000100,
        PH_TX_END = 6'b001000,
        PH_RX_LO  = 6'b010000,
        PH_RX_HI  = 6'b100000
    } phase_t;

    // Command codes carried by an input item.
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_SEND  = 3'd1;
    localparam logic [2:0] ACT_RECV  = 3'd2;
    localparam logic [2:0] ACT_OPEN  = 3'd3;
    localparam logic [2:0] ACT_CLOSE = 3'd4;

    // Control line values.
    localparam logic [5:0] CTL_STROBE = 6'h21;
    localparam logic [5:0] CTL_ACK    = 6'h00;
    localparam logic [5:0] CTL_REST   = 6'h01;
    localparam logic [5:0] CTL_OFF    = 6'h00;

    // Data line values.
    localparam logic [7:0] DATA_OPEN  = 8'hFF;
    localparam logic [7:0] DATA_CLOSE = 8'h00;
    localparam logic [3:0] DATA_HIGH  = 4'hF;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

endpackage

/* src/parallel_port_nibble_link_unit.sv */
// ---------------------------------------------------------------------------
// Parallel port nibble link unit
// Poll-driven nibble-mode handshake engine: moves one byte as two nibbles,
// low nibble first, with a bounded poll count on every handshake wait.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  --------  ---------  --------------------  --------------------------------
//  in        to block   in_valid / in_stall   action, tx_byte, handshake_line,
//                                             nibble_in
//  out       from block out_valid / out_stall control_lines, data_lines,
//                                             rx_byte, idle, done_res,
//                                             timed_out
//  cfg       to block   cfg_valid / cfg_ready cfg_data (timeout_polls)
//
// Each input item is one poll tick and yields exactly one result item. The
// handshake state and the result are computed combinationally from the item
// and state registers, so a new item can be taken on every clock unless stalled.
// The only storage between the two sides is the result register; the block
// stalls its input only while that register is full and the output is stalled.
// rst_n clears all handshake state, empties the result register and loads
// the timeout with 1000 polls. Configuration writes are always taken.
// ---------------------------------------------------------------------------
module parallel_port_nibble_link_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [7:0]  tx_byte,
    input  logic        handshake_line,
    input  logic [3:0]  nibble_in,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  control_lines,
    output logic [7:0]  data_lines,
    output logic [7:0]  rx_byte,
    output logic        idle,
    output logic        done_res,
    output logic        timed_out,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import ppnl_pkg::*;

    // Handshake state.
    phase_t      phase_reg,   phase_next;
    logic        second_reg,  second_next;
    logic        is_rx_reg,   is_rx_next;
    logic [15:0] wait_reg,    wait_next;
    logic [7:0]  shift_reg,   shift_next;
    logic [5:0]  ctl_reg,     ctl_next;
    logic [7:0]  data_reg,    data_next;
    logic [15:0] timeout_reg;

    // Result register.
    logic        out_valid_reg;
    logic [7:0]  rx_reg;
    logic        idle_reg;
    logic        done_reg;
    logic        tmo_reg;

    logic        in_fire;
    logic        done_c;
    logic        tmo_c;
    logic [7:0]  rx_c;
    logic        want_high;
    logic        line_ok;
    logic        expired;
    logic [15:0] wait_inc;
    logic [3:0]  tx_nibble;

    // The input only waits when a result is held and cannot leave this cycle.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // One poll of the current wait. A zero timeout expires on the first
    // miss, the same as a timeout of one.
    assign want_high = (phase_reg == PH_TX_HI) || (phase_reg == PH_TX_END)
                    || (phase_reg == PH_RX_HI);
    assign line_ok   = (handshake_line == want_high);
    assign wait_inc  = wait_reg + 16'd1;
    assign expired   = (wait_inc >= timeout_reg);
    assign tx_nibble = second_reg ? shift_reg[7:4] : shift_reg[3:0];

    always_comb
    begin
        phase_next  = phase_reg;
        second_next = second_reg;
        is_rx_next  = is_rx_reg;
        wait_next   = wait_reg;
        shift_next  = shift_reg;
        ctl_next    = ctl_reg;
        data_next   = data_reg;
        done_c      = 1'b0;
        tmo_c       = 1'b0;
        rx_c        = 8'h00;

        if (phase_reg == PH_IDLE)
        begin
            // Commands are taken only between transfers.
            priority if (action == ACT_SEND || action == ACT_RECV)
            begin
                is_rx_next  = (action == ACT_RECV);
                shift_next  = (action == ACT_SEND) ? tx_byte : 8'h00;
                second_next = 1'b0;
                wait_next   = 16'd0;
                ctl_next    = CTL_STROBE;
                phase_next  = (action == ACT_RECV) ? PH_RX_LO : PH_TX_HI;
            end
            else if (action == ACT_OPEN)
            begin
                data_next = DATA_OPEN;
                ctl_next  = CTL_REST;
            end
            else if (action == ACT_CLOSE)
            begin
                data_next = DATA_CLOSE;
                ctl_next  = CTL_OFF;
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end
        else if (!line_ok)
        begin
            if (expired)
            begin
                wait_next  = 16'd0;
                done_c     = 1'b1;
                tmo_c      = 1'b1;
                phase_next = PH_IDLE;
            end
            else
            begin
                wait_next = wait_inc;
            end
        end
        else
        begin
            // The line has the wanted level: take the next handshake step.
            wait_next = 16'd0;
            unique case (phase_reg)
                PH_TX_HI:
                begin
                    data_next  = {DATA_HIGH, tx_nibble};
                    ctl_next   = CTL_ACK;
                    phase_next = PH_TX_LO;
                end
                PH_TX_LO:
                begin
                    if (second_reg)
                    begin
                        ctl_next   = CTL_REST;
                        phase_next = PH_TX_END;
                    end
                    else
                    begin
                        second_next = 1'b1;
                        ctl_next    = CTL_STROBE;
                        phase_next  = PH_TX_HI;
                    end
                end
                PH_TX_END:
                begin
                    done_c     = 1'b1;
                    phase_next = PH_IDLE;
                end
                PH_RX_LO:
                begin
                    if (second_reg)
                        shift_next = {nibble_in, shift_reg[3:0]};
                    else
                        shift_next = {4'h0, nibble_in};
                    ctl_next   = CTL_ACK;
                    phase_next = PH_RX_HI;
                end
                PH_RX_HI:
                begin
                    if (second_reg)
                    begin
                        ctl_next   = CTL_REST;
                        done_c     = 1'b1;
                        rx_c       = shift_reg;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        second_next = 1'b1;
                        ctl_next    = CTL_STROBE;
                        phase_next  = PH_RX_LO;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // State advances once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            second_reg  <= 1'b0;
            is_rx_reg   <= 1'b0;
            wait_reg    <= 16'd0;
            shift_reg   <= 8'h00;
            ctl_reg     <= CTL_OFF;
            data_reg    <= 8'h00;
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg  <= phase_next;
                second_reg <= second_next;
                is_rx_reg  <= is_rx_next;
                wait_reg   <= wait_next;
                shift_reg  <= shift_next;
                ctl_reg    <= ctl_next;
                data_reg   <= data_next;
            end
            if (cfg_valid && cfg_ready)
                timeout_reg <= cfg_data;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Result payload; the line values come straight from the state registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rx_reg   <= rx_c;
            idle_reg <= (phase_next == PH_IDLE);
            done_reg <= done_c;
            tmo_reg  <= tmo_c;
        end
    end

    assign out_valid     = out_valid_reg;
    assign control_lines = ctl_reg;
    assign data_lines    = data_reg;
    assign rx_byte       = rx_reg;
    assign idle          = idle_reg;
    assign done_res      = done_reg;
    assign timed_out     = tmo_reg;

endmodule

/* src/ppnl_checker.sv */
// ---------------------------------------------------------------------------
// Parallel port nibble link checker
// Port-level checks on result items, bound to the link unit.
// ---------------------------------------------------------------------------
`include "parallel_port_nibble_link_unit_macros.svh"

module ppnl_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [5:0]  control_lines,
    input logic [7:0]  data_lines,
    input logic [7:0]  rx_byte,
    input logic        idle,
    input logic        done_res,
    input logic        timed_out
);

    logic        tmo_seen;
    logic        rx_seen;
    logic        clean_end;
    logic        done_seen;
    logic        held;
    logic [26:0] res_bits;

    assign tmo_seen  = out_valid && timed_out;
    assign rx_seen   = out_valid && (rx_byte != 8'h00);
    assign clean_end = done_res && !timed_out;
    assign done_seen = out_valid && done_res;
    assign held      = out_valid && out_stall;
    assign res_bits  = {control_lines, data_lines, rx_byte, idle, done_res, timed_out};

    // A timeout is always reported as the end of a transfer.
    `PPNL_ASSERT_NOW(a_tmo_done, clk, rst_n, tmo_seen, done_res, "timeout without done")

    // A received byte only appears on a transfer that ended cleanly.
    `PPNL_ASSERT_NOW(a_rx_clean, clk, rst_n, rx_seen, clean_end, "rx byte outside a clean end")

    // Every finished transfer leaves the link ready for a new command.
    `PPNL_ASSERT_NOW(a_done_idle, clk, rst_n, done_seen, idle, "done while still busy")

    // A stalled result is held unchanged.
    `PPNL_ASSERT_NEXT(a_out_hold, clk, rst_n, held, out_valid && $stable(res_bits), "result not held")

endmodule

bind parallel_port_nibble_link_unit ppnl_checker u_ppnl_checker (.*);
